@@ sv/fixed_point_math_unit_macros.svh @@
// Assertion macros for the fixed-point math unit.
`ifndef FIXED_POINT_MATH_UNIT_MACROS_SVH
`define FIXED_POINT_MATH_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define FPMU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define FPMU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ sv/fpmu_pkg.sv @@
// Shared types, constants and opcodes for the fixed-point math unit.
package fpmu_pkg;
  localparam int FracDef     = 16;
  localparam int WordBitsDef = 64;
  localparam int RootBitsDef = 32;
  localparam int ExpLimitDef = 127;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_POW  = 2'd2;
  localparam logic [1:0] OP_SQRT = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } in_beat_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic               error_flag;
  } out_beat_t;

  // Request to a serial arithmetic unit.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } unit_req_t;
endpackage

@@ sv/fpmu_mul.sv @@
// Bit-serial fixed-point multiplier: one multiplier bit per cycle.
module fpmu_mul #(
  parameter int FRAC      = fpmu_pkg::FracDef,
  parameter int WORD_BITS = fpmu_pkg::WordBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpmu_pkg::unit_req_t req,
  output logic                done,
  output logic [63:0]         prod
);
  localparam int CntW = $clog2(2 * WORD_BITS + 1);
  localparam int PW   = 2 * WORD_BITS;

  logic [PW-1:0]   mcand_r, mcand_nxt;   // sign-extended multiplicand, shifted left
  logic [PW-1:0]   mplier_r, mplier_nxt; // sign-extended multiplier, shifted right
  logic [PW-1:0]   acc_r, acc_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [PW-1:0]   shifted;

  always_comb begin
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      mcand_nxt  = PW'($signed(req.a[WORD_BITS-1:0]));
      mplier_nxt = PW'($signed(req.b[WORD_BITS-1:0]));
      acc_nxt    = '0;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      // Product mod 2^PW of sign-extended operands equals the signed product.
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == CntW'(PW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
  end

  assign shifted = acc_r >> FRAC;
  assign done    = done_r;
  assign prod    = 64'($signed(shifted[WORD_BITS-1:0]));
endmodule

@@ sv/fpmu_div.sv @@
// Restoring divider, one quotient bit per cycle; a divided by b with FRAC shift.
module fpmu_div #(
  parameter int FRAC      = fpmu_pkg::FracDef,
  parameter int WORD_BITS = fpmu_pkg::WordBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpmu_pkg::unit_req_t req,
  output logic                done,
  output logic [63:0]         quot
);
  localparam int NW   = 64 + FRAC;
  localparam int CntW = $clog2(NW + 1);

  logic [NW-1:0]   num_r, num_nxt;
  logic [63:0]     d_r, d_nxt;
  logic [63:0]     rem_r, rem_nxt;
  logic [63:0]     q_r, q_nxt;
  logic            neg_r, neg_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [64:0]     trial;
  logic [63:0]     qfix;
  logic [63:0]     ua, ub;

  always_comb begin
    ua = req.a[63] ? 64'(-req.a) : req.a;
    ub = req.b[63] ? 64'(-req.b) : req.b;
    trial = {rem_r, num_r[NW-1]};
    num_nxt  = num_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      num_nxt  = {ua, FRAC'(0)};
      d_nxt    = ub;
      rem_nxt  = '0;
      q_nxt    = '0;
      neg_nxt  = req.a[63] ^ req.b[63];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = 64'(trial - {1'b0, d_r});
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[63:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
  end

  assign qfix = neg_r ? 64'(-q_r) : q_r;
  assign done = done_r;
  assign quot = 64'($signed(qfix[WORD_BITS-1:0]));
endmodule

@@ sv/fixed_point_math_unit.sv @@
// Top level of the fixed-point math unit: sequencer for mul, div, pow, sqrt.
// Result strobed in the done state: a multiply takes one multiplier pass, a divide one
// divider pass, a power one pass per unit of exponent magnitude n, a square root up to
// ROOT_BITS trial squares; errors and zero exponent go straight to the done state.
// One beat at a time; busy holds through the strobe, next beat in the cycle after it.
// Synchronous active-low reset idles the sequencer; results cannot be stalled.
`include "fixed_point_math_unit_macros.svh"
module fixed_point_math_unit #(
  parameter int FRAC      = fpmu_pkg::FracDef,
  parameter int WORD_BITS = fpmu_pkg::WordBitsDef,
  parameter int ROOT_BITS = fpmu_pkg::RootBitsDef,
  parameter int EXP_LIMIT = fpmu_pkg::ExpLimitDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fpmu_pkg::in_beat_t  in_data,
  output logic                out_valid,
  output fpmu_pkg::out_beat_t out_data
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1; // waiting on multiplier (mul, pow+)
  localparam logic [2:0] ST_DIV  = 3'd2; // waiting on divider (div, pow-)
  localparam logic [2:0] ST_SQRT = 3'd3; // waiting on trial square
  localparam logic [2:0] ST_DONE = 3'd4;
  localparam int RkW = $clog2(ROOT_BITS + 1);

  logic [2:0]  st_r, st_nxt;
  logic [63:0] a_r, a_nxt;     // word-wrapped operand a
  logic [63:0] acc_r, acc_nxt; // running result / root
  logic [63:0] prev_r, prev_nxt;
  logic [9:0]  left_r, left_nxt; // power iterations left
  logic [RkW-1:0] k_r, k_nxt;    // sqrt bits left
  logic        err_r, err_nxt;
  fpmu_pkg::unit_req_t mreq, dreq;
  logic        mdone, ddone;
  logic [63:0] mprod, dquot;
  logic [63:0] a_w, b_w, one_w, emag;
  logic        sq_gt;

  function automatic logic [63:0] wrap(input logic [63:0] x);
    wrap = 64'($signed(x[WORD_BITS-1:0]));
  endfunction

  fpmu_mul #(.FRAC(FRAC), .WORD_BITS(WORD_BITS)) u_mul (
    .clk, .rst_n, .req(mreq), .done(mdone), .prod(mprod));
  fpmu_div #(.FRAC(FRAC), .WORD_BITS(WORD_BITS)) u_div (
    .clk, .rst_n, .req(dreq), .done(ddone), .quot(dquot));

  always_comb begin
    a_w   = wrap(in_data.operand_a);
    b_w   = wrap(in_data.operand_b);
    one_w = wrap(64'd1 << FRAC);
    emag  = in_data.operand_b[63] ? 64'(-in_data.operand_b) : in_data.operand_b;
    sq_gt = $signed(mprod) > $signed(a_r);
    st_nxt = st_r; a_nxt = a_r; acc_nxt = acc_r;
    prev_nxt = prev_r; left_nxt = left_r; k_nxt = k_r; err_nxt = err_r;
    mreq = '0;
    dreq = '0;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          a_nxt  = a_w;
          err_nxt = 1'b0;
          acc_nxt = '0;
          case (in_data.req_type)
            fpmu_pkg::OP_MUL: begin
              mreq = '{start: 1'b1, a: a_w, b: b_w};
              left_nxt = 10'd1;
              st_nxt = ST_MUL;
            end
            fpmu_pkg::OP_DIV: begin
              if (b_w == '0) begin
                err_nxt = 1'b1;
                st_nxt = ST_DONE;
              end else begin
                dreq = '{start: 1'b1, a: a_w, b: b_w};
                left_nxt = 10'd1;
                st_nxt = ST_DIV;
              end
            end
            fpmu_pkg::OP_POW: begin
              acc_nxt = one_w;
              if (emag > 64'(EXP_LIMIT) ||
                  (in_data.operand_b[63] && a_w == '0)) begin
                err_nxt = 1'b1;
                acc_nxt = '0;
                st_nxt = ST_DONE;
              end else if (emag == '0) begin
                st_nxt = ST_DONE;
              end else begin
                left_nxt = emag[9:0];
                if (in_data.operand_b[63]) begin
                  dreq = '{start: 1'b1, a: one_w, b: a_w};
                  st_nxt = ST_DIV;
                end else begin
                  mreq = '{start: 1'b1, a: one_w, b: a_w};
                  st_nxt = ST_MUL;
                end
              end
            end
            default: begin
              if (a_w[63]) begin
                st_nxt = ST_DONE;
              end else begin
                k_nxt = RkW'(ROOT_BITS);
                prev_nxt = '0;
                acc_nxt = wrap(64'd1 << (ROOT_BITS - 1));
                mreq = '{start: 1'b1, a: acc_nxt, b: acc_nxt};
                st_nxt = ST_SQRT;
              end
            end
          endcase
        end
      end
      ST_MUL, ST_DIV: begin
        if ((st_r == ST_MUL && mdone) || (st_r == ST_DIV && ddone)) begin
          acc_nxt  = (st_r == ST_MUL) ? mprod : dquot;
          left_nxt = left_r - 1'b1;
          if (left_r == 10'd1) begin
            st_nxt = ST_DONE;
          end else if (st_r == ST_MUL) begin
            mreq = '{start: 1'b1, a: mprod, b: a_r};
          end else begin
            dreq = '{start: 1'b1, a: dquot, b: a_r};
          end
        end
      end
      ST_SQRT: begin
        if (mdone) begin
          if (mprod == a_r) begin
            st_nxt = ST_DONE;
          end else begin
            if (sq_gt) acc_nxt = prev_r;
            k_nxt = k_r - 1'b1;
            if (k_r == RkW'(1)) begin
              st_nxt = ST_DONE;
            end else begin
              prev_nxt = acc_nxt;
              acc_nxt  = wrap(acc_nxt | (64'd1 << (k_r - 2'd2)));
              mreq = '{start: 1'b1, a: acc_nxt, b: acc_nxt};
            end
          end
        end
      end
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    a_r <= a_nxt; acc_r <= acc_nxt; prev_r <= prev_nxt;
    left_r <= left_nxt; k_r <= k_nxt; err_r <= err_nxt;
  end

  assign busy      = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_DONE);
  assign out_data.result_value = err_r ? 64'd0 : acc_r;
  assign out_data.error_flag   = err_r;

  `FPMU_ASSERT_IMP(a_err_zero, out_valid && out_data.error_flag,
    out_data.result_value == 64'd0, "error result not zero")
  `FPMU_ASSERT_NXT(a_done_idle, out_valid, !busy, "no idle after result")
  `FPMU_ASSERT_IMP(a_one_unit, 1'b1, !(mdone && ddone), "both units finished")
endmodule

@@ bench/fixed_point_math_unit_test.sv @@
// Self-checking bench for the fixed-point math unit: directed and random beats.
module fixed_point_math_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = fpmu_pkg::FracDef;
  localparam int ROOT_BITS = fpmu_pkg::RootBitsDef;
  localparam int EXP_LIMIT = fpmu_pkg::ExpLimitDef;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  fpmu_pkg::in_beat_t in_data = '0;
  logic out_valid;
  fpmu_pkg::out_beat_t out_data;

  fixed_point_math_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fpmu_pkg::out_beat_t expected_q[$];
  int fail_count = 0;
  bit no_gaps = 1'b0;

  // Fixed-point product: full 128-bit signed product, arithmetic shift, wrap.
  function automatic logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >>> FRAC;
    return p[63:0];
  endfunction

  // Fixed-point quotient, truncated toward zero; b nonzero.
  function automatic logic signed [63:0] q_div(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [127:0] n, d, q;
    n = 128'(a) <<< FRAC;
    d = 128'(b);
    q = n / d;
    return q[63:0];
  endfunction

  function automatic logic signed [63:0] q_sqrt(logic signed [63:0] a);
    logic signed [63:0] root, prev, sq;
    root = '0;
    if (a < 0) return '0;
    for (int k = ROOT_BITS - 1; k >= 0; k--) begin
      prev = root;
      root = root | (64'sd1 << k);
      sq = q_mul(root, root);
      if (sq == a) return root;
      if (sq > a) root = prev;
    end
    return root;
  endfunction

  function automatic fpmu_pkg::out_beat_t predict_math(fpmu_pkg::in_beat_t b);
    fpmu_pkg::out_beat_t r;
    logic [63:0] mag;
    r = '0;
    case (b.req_type)
      fpmu_pkg::OP_MUL: r.result_value = q_mul(b.operand_a, b.operand_b);
      fpmu_pkg::OP_DIV: begin
        if (b.operand_b == 0) r.error_flag = 1'b1;
        else r.result_value = q_div(b.operand_a, b.operand_b);
      end
      fpmu_pkg::OP_POW: begin
        mag = b.operand_b[63] ? -b.operand_b : b.operand_b;
        if (mag > EXP_LIMIT || (b.operand_b[63] && b.operand_a == 0)) begin
          r.error_flag = 1'b1;
        end else begin
          r.result_value = 64'sd1 <<< FRAC;
          for (int n = 0; n < mag; n++)
            r.result_value = b.operand_b[63] ? q_div(r.result_value, b.operand_a)
                                             : q_mul(r.result_value, b.operand_a);
        end
      end
      default: r.result_value = q_sqrt(b.operand_a);
    endcase
    return r;
  endfunction

  // Send one beat: optional random idle, then hold start until accepted.
  // start stays high on return; a random idle in the next call or the end of the run drops it.
  task automatic send_beat(logic [1:0] op, logic signed [63:0] a, logic signed [63:0] b);
    fpmu_pkg::in_beat_t beat;
    beat.req_type = op;
    beat.operand_a = a;
    beat.operand_b = b;
    if (!no_gaps && $urandom_range(99) < 29) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 29);
    end
    start <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy);
    // accepted at this edge
    expected_q.push_back(predict_math(beat));
  endtask

  // Result checker: out_valid is a one-cycle strobe sampled at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", out_data);
        fail_count++;
      end else begin
        fpmu_pkg::out_beat_t e;
        e = expected_q.pop_front();
        if (out_data.result_value !== e.result_value) begin
          $error("result_value expected %h actual %h", e.result_value, out_data.result_value);
          fail_count++;
        end
        if (out_data.error_flag !== e.error_flag) begin
          $error("error_flag expected %b actual %b", e.error_flag, out_data.error_flag);
          fail_count++;
        end
      end
    end
  end

  function automatic logic signed [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Fixed-point value, often of modest size, so products do not always wrap.
  function automatic logic signed [63:0] rand_fx();
    case ($urandom_range(3))
      0: return rand64();
      1: return 64'($signed($urandom_range(8000000))) - 64'sd4000000;
      2: return $signed(64'(int'($urandom())));
      default: return ($urandom_range(1) ? -64'sd1 : 64'sd1) <<< $urandom_range(FRAC + 8);
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [63:0] mx, mn, one;
    mx = 64'h7fff_ffff_ffff_ffff;
    mn = 64'h8000_0000_0000_0000;
    one = 64'sd1 <<< FRAC;
    send_beat(fpmu_pkg::OP_MUL, mx, mx);
    send_beat(fpmu_pkg::OP_MUL, mn, mn);
    send_beat(fpmu_pkg::OP_MUL, mn, -64'sd1);
    send_beat(fpmu_pkg::OP_MUL, one, -one);
    send_beat(fpmu_pkg::OP_DIV, one, 64'sd0);        // divide by zero
    send_beat(fpmu_pkg::OP_DIV, mn, -64'sd1);
    send_beat(fpmu_pkg::OP_DIV, mx, one);
    send_beat(fpmu_pkg::OP_DIV, -one * 7, one * 2);
    send_beat(fpmu_pkg::OP_SQRT, mx, 64'sd0);
    send_beat(fpmu_pkg::OP_SQRT, -one, mx);          // negative root
    send_beat(fpmu_pkg::OP_SQRT, one * 4, 64'sd0);   // exact match
    send_beat(fpmu_pkg::OP_SQRT, 64'sd0, 64'sd0);
  endtask

  task automatic test_power_cases();
    logic signed [63:0] one;
    one = 64'sd1 <<< FRAC;
    send_beat(fpmu_pkg::OP_POW, one * 3, 64'sd0);          // zero exponent
    send_beat(fpmu_pkg::OP_POW, one * 2, EXP_LIMIT);
    send_beat(fpmu_pkg::OP_POW, one * 2, -EXP_LIMIT);
    send_beat(fpmu_pkg::OP_POW, one, EXP_LIMIT + 1);       // exponent out of range
    send_beat(fpmu_pkg::OP_POW, one, -EXP_LIMIT - 1);
    send_beat(fpmu_pkg::OP_POW, one, 64'h8000_0000_0000_0000);
    send_beat(fpmu_pkg::OP_POW, 64'sd0, -64'sd3);          // negative power of zero
    send_beat(fpmu_pkg::OP_POW, 64'sd0, 64'sd5);
    send_beat(fpmu_pkg::OP_POW, -one * 3, 64'sd5);
    send_beat(fpmu_pkg::OP_POW, one / 2, -64'sd4);
  endtask

  task automatic test_random(int count);
    logic [1:0] op;
    logic signed [63:0] a, b;
    for (int i = 0; i < count; i++) begin
      no_gaps = (i >= count / 2) && (i < count / 2 + 150);
      op = 2'($urandom_range(3));
      a = rand_fx();
      b = rand_fx();
      if (op == fpmu_pkg::OP_POW) begin
        case ($urandom_range(5))
          0: b = rand64();   // mostly out of range
          1: b = $signed(64'($urandom_range(2 * EXP_LIMIT + 8))) - EXP_LIMIT - 4;
          default: b = $signed(64'($urandom_range(16))) - 8;
        endcase
        if ($urandom_range(15) == 0) a = 0;
      end else if (op == fpmu_pkg::OP_DIV && $urandom_range(15) == 0) begin
        b = 0;
      end else if (op == fpmu_pkg::OP_SQRT && $urandom_range(3) == 0) begin
        a = q_mul(b, b);   // likely exact square
      end
      send_beat(op, a, b);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_power_cases();
    test_random(1250);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("fixed_point_math_unit_test: PASS");
    end else begin
      $display("fixed_point_math_unit_test: FAIL");
    end
    $finish;
  end

  // Watchdog: well above every beat taking 127 serial ops.
  initial begin
    #1000ms;
    $display("fixed_point_math_unit_test: FAIL");
    $finish;
  end
endmodule
